[rtl/lhx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_pkg
// Shared sizes, codes, item types and the counter update rule of the
// local history XOR branch predictor.
// ----------------------------------------------------------------------------
package lhx_pkg;

   // table geometry
   localparam int COUNTER_ENTRIES = 1024;
   localparam int COUNTER_BITS    = 2;
   localparam int HISTORY_ENTRIES = 256;
   localparam int HIST_BITS       = 8;
   localparam int CIDX_W          = $clog2(COUNTER_ENTRIES);
   localparam int HIDX_W          = $clog2(HISTORY_ENTRIES);

   // port widths
   localparam int ADDR_W     = 32;
   localparam int SHIFT_W    = 3;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // register reset values
   localparam logic [SHIFT_W-1:0] PC_SHIFT_RESET  = SHIFT_W'(2);
   localparam logic [MASK_W-1:0]  HIST_MASK_RESET = MASK_W'(255);

   // opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PC_SHIFT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HIST_MASK = CSR_IDX_W'(1);

   // one classified beat as it sits in the queue
   typedef struct packed {
      logic              do_update;
      logic              taken;
      logic [HIDX_W-1:0] hidx;
      logic [CIDX_W-1:0] pc_bits;
   } lhx_item_type;

   // flow control seen by the front
   typedef struct packed {
      logic queue_full;
      logic clear_active;
   } lhx_flow_type;

   // saturating counter step toward the outcome
   function automatic logic [COUNTER_BITS-1:0] ctr_next(
      input logic [COUNTER_BITS-1:0] ctr,
      input logic                    taken
   );
      logic [COUNTER_BITS-1:0] res;
      res = ctr;
      if (taken) begin
         if (ctr != {COUNTER_BITS{1'b1}}) res = ctr + COUNTER_BITS'(1);
      end else begin
         if (ctr != {COUNTER_BITS{1'b0}}) res = ctr - COUNTER_BITS'(1);
      end
      return res;
   endfunction

endpackage

[rtl/lhx_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lhx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/lhx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_front
// Config registers, request accept and classification into queue beats.
// ----------------------------------------------------------------------------
module lhx_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic [lhx_pkg::ADDR_W-1:0]         req_branch_addr,
   input  logic                               req_taken,
   input  logic                               req_squashed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lhx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhx_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  lhx_pkg::lhx_flow_type              flow,
   output logic                               push,
   output lhx_pkg::lhx_item_type              item
);

   logic [lhx_pkg::SHIFT_W-1:0] pc_shift_ff,  pc_shift_in;
   logic [lhx_pkg::MASK_W-1:0]  hist_mask_ff, hist_mask_in;
   logic [lhx_pkg::CIDX_W-1:0]  shifted;

   assign csr_ready = 1'b1;

   always_comb begin
      pc_shift_in  = pc_shift_ff;
      hist_mask_in = hist_mask_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lhx_pkg::CSR_PC_SHIFT:  pc_shift_in  = csr_wdata[lhx_pkg::SHIFT_W-1:0];
            lhx_pkg::CSR_HIST_MASK: hist_mask_in = csr_wdata[lhx_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_shift_ff  <= lhx_pkg::PC_SHIFT_RESET;
         hist_mask_ff <= lhx_pkg::HIST_MASK_RESET;
      end else begin
         pc_shift_ff  <= pc_shift_in;
         hist_mask_ff <= hist_mask_in;
      end
   end

   assign busy = flow.queue_full | flow.clear_active;
   assign push = start & ~busy;

   // only the low counter-index bits of the shifted address are ever used
   assign shifted = lhx_pkg::CIDX_W'(req_branch_addr >> pc_shift_ff);

   always_comb begin
      item.do_update = (req_opcode == lhx_pkg::OP_UPDATE) & ~req_squashed;
      item.taken     = req_taken;
      item.hidx      = shifted[lhx_pkg::HIDX_W-1:0] & hist_mask_ff;
      item.pc_bits   = shifted;
   end

endmodule

[rtl/lhx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_queue
// Small FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module lhx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lhx_pkg::lhx_item_type push_item,
   input  logic                  pop,
   output lhx_pkg::lhx_item_type head,
   output logic                  full,
   output logic                  empty
);

   lhx_pkg::lhx_item_type           slot_ff [lhx_pkg::QUEUE_DEPTH];
   logic [lhx_pkg::QPTR_W-1:0]      wptr_ff, wptr_in;
   logic [lhx_pkg::QPTR_W-1:0]      rptr_ff, rptr_in;
   logic [lhx_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == lhx_pkg::QCNT_W'(lhx_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == lhx_pkg::QPTR_W'(lhx_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wptr_ff + lhx_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == lhx_pkg::QPTR_W'(lhx_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rptr_ff + lhx_pkg::QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + lhx_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - lhx_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_item;
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

[rtl/lhx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_back
// Table sequencer: clear sweep, history read, counter read, response and
// write back.
// ----------------------------------------------------------------------------
module lhx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lhx_pkg::lhx_item_type head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  clear_active,
   output logic                  rsp_valid,
   output logic                  rsp_predict_taken
);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HIST, S_CTR} state_type;

   state_type                         state_ff, state_in;
   logic [lhx_pkg::CIDX_W-1:0]        clr_idx_ff, clr_idx_in;
   lhx_pkg::lhx_item_type             item_ff, item_in;
   logic [lhx_pkg::CIDX_W-1:0]        cidx_ff, cidx_in;
   logic [lhx_pkg::HIST_BITS-1:0]     hist_ff, hist_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_pred_ff, rsp_pred_in;

   logic                              hist_we, hist_re;
   logic [lhx_pkg::HIDX_W-1:0]        hist_waddr;
   logic [lhx_pkg::HIST_BITS-1:0]     hist_wdata, hist_rdata;
   logic                              ctr_we, ctr_re;
   logic [lhx_pkg::CIDX_W-1:0]        ctr_waddr, ctr_raddr;
   logic [lhx_pkg::COUNTER_BITS-1:0]  ctr_wdata, ctr_rdata;

   lhx_ram #(
      .WIDTH (lhx_pkg::HIST_BITS),
      .DEPTH (lhx_pkg::HISTORY_ENTRIES)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (hist_re),
      .raddr (head.hidx),
      .rdata (hist_rdata)
   );

   lhx_ram #(
      .WIDTH (lhx_pkg::COUNTER_BITS),
      .DEPTH (lhx_pkg::COUNTER_ENTRIES)
   ) u_ctr_ram (
      .clock (clock),
      .we    (ctr_we),
      .waddr (ctr_waddr),
      .wdata (ctr_wdata),
      .re    (ctr_re),
      .raddr (ctr_raddr),
      .rdata (ctr_rdata)
   );

   // counter index: history XOR shifted pc bits
   assign ctr_raddr = lhx_pkg::CIDX_W'(hist_rdata) ^ item_ff.pc_bits;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      item_in      = item_ff;
      cidx_in      = cidx_ff;
      hist_in      = hist_ff;
      rsp_valid_in = 1'b0;
      rsp_pred_in  = rsp_pred_ff;
      pop          = 1'b0;
      hist_re      = 1'b0;
      ctr_re       = 1'b0;
      hist_we      = 1'b0;
      hist_waddr   = item_ff.hidx;
      hist_wdata   = {hist_ff[lhx_pkg::HIST_BITS-2:0], item_ff.taken};
      ctr_we       = 1'b0;
      ctr_waddr    = cidx_ff;
      ctr_wdata    = lhx_pkg::ctr_next(ctr_rdata, item_ff.taken);

      unique case (state_ff)
         S_CLEAR: begin
            // history table is smaller; its rows just get cleared repeatedly
            hist_we    = 1'b1;
            hist_waddr = clr_idx_ff[lhx_pkg::HIDX_W-1:0];
            hist_wdata = '0;
            ctr_we     = 1'b1;
            ctr_waddr  = clr_idx_ff;
            ctr_wdata  = '0;
            clr_idx_in = clr_idx_ff + lhx_pkg::CIDX_W'(1);
            if (&clr_idx_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               hist_re  = 1'b1;
               item_in  = head;
               state_in = S_HIST;
            end
         end
         S_HIST: begin
            ctr_re   = 1'b1;
            cidx_in  = ctr_raddr;
            hist_in  = hist_rdata;
            state_in = S_CTR;
         end
         S_CTR: begin
            rsp_valid_in = 1'b1;
            rsp_pred_in  = ctr_rdata[lhx_pkg::COUNTER_BITS-1];
            hist_we      = item_ff.do_update;
            ctr_we       = item_ff.do_update;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cidx_ff     <= cidx_in;
      hist_ff     <= hist_in;
      rsp_pred_ff <= rsp_pred_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign clear_active      = (state_ff == S_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_pred_ff;

   a_rsp_after_ctr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_CTR))
      else $error("response without counter read");

   a_hist_then_ctr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HIST) |=> (state_ff == S_CTR))
      else $error("history read not followed by counter read");

endmodule

[rtl/local_history_xor_branch_predictor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_history_xor_branch_predictor_core
// Two-level predictor: per-branch 8-bit local history XOR pc bits indexes a
// table of saturating counters. Lookup and update beats, one response each.
// ----------------------------------------------------------------------------
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   ------------------------
//   request   req_opcode req_branch_addr req_taken   start & !busy
//             req_squashed
//   response  rsp_predict_taken                      rsp_valid, one cycle
//   config    csr_index csr_wdata                    csr_valid & csr_ready
//
// After reset the back sweeps both tables to zero with busy high; config
// writes are still taken.
// A request beat passes through the queue, history read, counter read and
// response register before the response strobe.
// The back takes a new beat only after it is done with the last, paced by its
// dependent history read then counter read on single-port-read RAMs.
// busy also rises when the 2-entry queue between front and back is full.
// Responses cannot be stalled; they come in request order.
//
module local_history_xor_branch_predictor_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic [lhx_pkg::ADDR_W-1:0]         req_branch_addr,
   input  logic                               req_taken,
   input  logic                               req_squashed,
   output logic                               rsp_valid,
   output logic                               rsp_predict_taken,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lhx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhx_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lhx_pkg::lhx_flow_type flow;
   lhx_pkg::lhx_item_type push_item;
   lhx_pkg::lhx_item_type head;
   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  clear_active;

   // front: config regs, shift/mask of the address, opcode classification
   assign flow.queue_full   = queue_full;
   assign flow.clear_active = clear_active;

   lhx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_branch_addr (req_branch_addr),
      .req_taken       (req_taken),
      .req_squashed    (req_squashed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .flow            (flow),
      .push            (push),
      .item            (push_item)
   );

   // decouples accept from table work
   lhx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // back: table reads, prediction, read-modify-write of both tables
   lhx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (queue_empty),
      .pop               (pop),
      .clear_active      (clear_active),
      .rsp_valid         (rsp_valid),
      .rsp_predict_taken (rsp_predict_taken)
   );

endmodule

[tb/sv/lhx_pred_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhx_pred_checker
// Watches the request, response and config channels of the predictor core.
// Keeps its own copy of both tables and the registers, works out the
// direction each accepted request should report, and compares responses
// in order.
// ----------------------------------------------------------------------------
module lhx_pred_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_opcode,
   input  logic [lhx_pkg::ADDR_W-1:0]         req_branch_addr,
   input  logic                               req_taken,
   input  logic                               req_squashed,
   input  logic                               rsp_valid,
   input  logic                               rsp_predict_taken,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lhx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhx_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);

   localparam logic [lhx_pkg::COUNTER_BITS-1:0] CTR_MAX = {lhx_pkg::COUNTER_BITS{1'b1}};
   localparam int REPORT_LIMIT = 10;

   logic [lhx_pkg::COUNTER_BITS-1:0] ctr_tbl  [lhx_pkg::COUNTER_ENTRIES];
   logic [lhx_pkg::HIST_BITS-1:0]    hist_tbl [lhx_pkg::HISTORY_ENTRIES];
   logic [lhx_pkg::SHIFT_W-1:0]      shift_amt;
   logic [lhx_pkg::MASK_W-1:0]       hist_mask;

   // predicted directions, oldest first
   logic predicted_dir_q [$];

   // direction from the tables as they stand, then train an unsquashed update on its outcome
   function automatic logic lookup_and_train(
      input logic                       op,
      input logic [lhx_pkg::ADDR_W-1:0] addr,
      input logic                       tk,
      input logic                       sq
   );
      logic [lhx_pkg::ADDR_W-1:0]       shifted;
      logic [lhx_pkg::HIDX_W-1:0]       hsel;
      logic [lhx_pkg::HIST_BITS-1:0]    hist;
      logic [lhx_pkg::CIDX_W-1:0]       cidx;
      logic [lhx_pkg::COUNTER_BITS-1:0] ctr;
      logic                             dir;
      shifted = addr >> shift_amt;
      hsel    = lhx_pkg::HIDX_W'(shifted) & lhx_pkg::HIDX_W'(hist_mask);
      hist    = hist_tbl[hsel];
      cidx    = lhx_pkg::CIDX_W'(hist) ^ shifted[lhx_pkg::CIDX_W-1:0];
      ctr     = ctr_tbl[cidx];
      dir     = ctr[lhx_pkg::COUNTER_BITS-1];
      if (op == lhx_pkg::OP_UPDATE && !sq) begin
         if (tk) begin
            if (ctr != CTR_MAX) ctr = ctr + lhx_pkg::COUNTER_BITS'(1);
         end else begin
            if (ctr != '0) ctr = ctr - lhx_pkg::COUNTER_BITS'(1);
         end
         ctr_tbl[cidx]  = ctr;
         hist_tbl[hsel] = {hist[lhx_pkg::HIST_BITS-2:0], tk};
      end
      return dir;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         for (int i = 0; i < lhx_pkg::COUNTER_ENTRIES; i++) ctr_tbl[i] = '0;
         for (int i = 0; i < lhx_pkg::HISTORY_ENTRIES; i++) hist_tbl[i] = '0;
         shift_amt  = lhx_pkg::PC_SHIFT_RESET;
         hist_mask  = lhx_pkg::HIST_MASK_RESET;
         fail_count = 0;
         predicted_dir_q.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_dir_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("[%0t] response beat with nothing outstanding: predict_taken=%0b",
                           $realtime, rsp_predict_taken);
               fail_count++;
            end else begin
               want = predicted_dir_q.pop_front();
               if (rsp_predict_taken !== want) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("[%0t] predict_taken mismatch: expected %0b got %0b",
                              $realtime, want, rsp_predict_taken);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            predicted_dir_q.push_back(lookup_and_train(req_opcode, req_branch_addr,
                                                       req_taken, req_squashed));
         if (csr_valid && csr_ready) begin
            if (csr_index == lhx_pkg::CSR_PC_SHIFT)
               shift_amt = csr_wdata[lhx_pkg::SHIFT_W-1:0];
            else if (csr_index == lhx_pkg::CSR_HIST_MASK)
               hist_mask = csr_wdata[lhx_pkg::MASK_W-1:0];
         end
      end
      pending = predicted_dir_q.size();
   end

endmodule

[tb/sv/local_history_xor_branch_predictor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_history_xor_branch_predictor_core_tb
// Drives lookup and update beats into the predictor core under several
// register settings, with bursty request traffic; a side checker predicts
// every response and this top reports the verdict.
// ----------------------------------------------------------------------------
module local_history_xor_branch_predictor_core_tb;

   // run bounds
   localparam int CYCLE_LIMIT    = 400000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES   = 16;      // padding after the last response
   localparam int PHASE_COUNT    = 5;
   localparam int PHASE_BEATS    = 285;
   localparam int POOL_SIZE      = 8;

   // indexes with no register behind them; writes must have no effect
   localparam logic [lhx_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = lhx_pkg::CSR_IDX_W'(2);
   localparam logic [lhx_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = lhx_pkg::CSR_IDX_W'(3);

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_opcode;
   logic [lhx_pkg::ADDR_W-1:0]     req_branch_addr;
   logic                           req_taken;
   logic                           req_squashed;
   logic                           rsp_valid;
   logic                           rsp_predict_taken;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [lhx_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lhx_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int cycle_count;

   // branch pool: a handful of hot branches with a fixed taken bias each, so
   // histories settle into patterns and counters reach both saturation ends
   logic [lhx_pkg::ADDR_W-1:0] branch_pool [POOL_SIZE];
   int unsigned                taken_pct   [POOL_SIZE];

   // burst shaping state for the sender
   int burst_left;

   local_history_xor_branch_predictor_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_branch_addr   (req_branch_addr),
      .req_taken         (req_taken),
      .req_squashed      (req_squashed),
      .rsp_valid         (rsp_valid),
      .rsp_predict_taken (rsp_predict_taken),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   lhx_pred_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_branch_addr   (req_branch_addr),
      .req_taken         (req_taken),
      .req_squashed      (req_squashed),
      .rsp_valid         (rsp_valid),
      .rsp_predict_taken (rsp_predict_taken),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** local_history_xor_branch_predictor_core: FAILED **");
         $finish;
      end
   end

   // One request beat. Called at a falling edge; fields go out now and stay
   // put until the rising edge that takes the beat. busy only moves after a
   // rising edge, so its value at the falling edge is what the next rising
   // edge sees. Returns at the falling edge after the accepting edge, with
   // start still high so a following beat can go back to back.
   task automatic send_beat(input logic op, input logic [lhx_pkg::ADDR_W-1:0] addr,
                            input logic tk, input logic sq);
      start           <= 1'b1;
      req_opcode      <= op;
      req_branch_addr <= addr;
      req_taken       <= tk;
      req_squashed    <= sq;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Register write, only with the core idle: every outstanding response
   // must have arrived, then the drain padding runs out.
   task automatic write_reg(input logic [lhx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lhx_pkg::CSR_DATA_W-1:0] data);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= lhx_pkg::CSR_DATA_W'($urandom);
   endtask

   // new hot branches for a phase; bias is strongly taken, strongly
   // not taken, or a coin flip
   task automatic refresh_pool();
      int pick;
      for (int i = 0; i < POOL_SIZE; i++) begin
         branch_pool[i] = $urandom;
         pick = $urandom_range(0, 2);
         taken_pct[i] = (pick == 0) ? 3 : (pick == 1) ? 97 : 50;
      end
   endtask

   // one random beat plus the idle gap that may follow it
   task automatic random_beat();
      int                         slot;
      int                         gap;
      logic                       op;
      logic                       tk;
      logic                       sq;
      logic [lhx_pkg::ADDR_W-1:0] addr;
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < 78) begin
         addr = branch_pool[slot];
         // nearby PCs alias onto the same history entries under some shifts
         if ($urandom_range(0, 9) == 0)
            addr = addr ^ lhx_pkg::ADDR_W'($urandom_range(1, 7));
      end else begin
         addr = $urandom;
      end
      if ($urandom_range(0, 99) < 40) begin
         // lookup: taken and squashed are don't-care, so randomize them
         op = lhx_pkg::OP_LOOKUP;
         tk = 1'($urandom_range(0, 1));
         sq = 1'($urandom_range(0, 1));
      end else begin
         op = lhx_pkg::OP_UPDATE;
         tk = ($urandom_range(0, 99) < taken_pct[slot]);
         sq = ($urandom_range(0, 9) == 0);
      end
      send_beat(op, addr, tk, sq);
      // bursts of random length; a quarter of the gaps are empty so long
      // back-to-back stretches occur
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start           <= 1'b0;
            req_branch_addr <= $urandom;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic run_phase();
      refresh_pool();
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_BEATS; n++) random_beat();
      start <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = lhx_pkg::OP_LOOKUP;
      req_branch_addr = '0;
      req_taken       = 1'b0;
      req_squashed    = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = lhx_pkg::CSR_PC_SHIFT;
      csr_wdata       = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed beats, reset register values (shift 2, full mask) ----
      // address extremes; lookup ignores taken and squashed
      send_beat(lhx_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0);
      send_beat(lhx_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // squashed update reports but changes nothing
      send_beat(lhx_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // not-taken update on a counter already at zero
      send_beat(lhx_pkg::OP_UPDATE, 32'h0000_0000, 1'b0, 1'b0);
      // ten taken updates on one branch: history fills and drops its top bit
      for (int i = 0; i < 10; i++)
         send_beat(lhx_pkg::OP_UPDATE, 32'h0000_1234, 1'b1, 1'b0);
      send_beat(lhx_pkg::OP_LOOKUP, 32'h0000_1234, 1'b0, 1'b0);
      // walk it back down
      for (int i = 0; i < 5; i++)
         send_beat(lhx_pkg::OP_UPDATE, 32'h0000_1234, 1'b0, 1'b0);
      send_beat(lhx_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_beat(lhx_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_beat(lhx_pkg::OP_UPDATE, 32'h8000_0001, 1'b0, 1'b0);
      start <= 1'b0;
      @(negedge clock);

      // ---- random phases, each under its own register setting ----
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin
               // no shift, mask zero: every branch shares history entry 0;
               // upper wdata bits set to show the shift field is 3 bits
               write_reg(lhx_pkg::CSR_PC_SHIFT, 8'hF8);
               write_reg(lhx_pkg::CSR_HIST_MASK, 8'h00);
            end
            1: begin
               write_reg(lhx_pkg::CSR_PC_SHIFT, 8'h07);
               write_reg(lhx_pkg::CSR_HIST_MASK, 8'hFF);
            end
            2: begin
               // writes to unmapped indexes are dropped
               write_reg(CSR_SPARE_LO, lhx_pkg::CSR_DATA_W'($urandom));
               write_reg(CSR_SPARE_HI, lhx_pkg::CSR_DATA_W'($urandom));
               write_reg(lhx_pkg::CSR_PC_SHIFT, 8'h03);
               write_reg(lhx_pkg::CSR_HIST_MASK, 8'h0F);
            end
            default: begin
               write_reg(lhx_pkg::CSR_PC_SHIFT, lhx_pkg::CSR_DATA_W'($urandom));
               write_reg(lhx_pkg::CSR_HIST_MASK, lhx_pkg::CSR_DATA_W'($urandom));
            end
         endcase
         run_phase();
      end

      // drain, then give the pipeline time to show any stray response
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("** local_history_xor_branch_predictor_core: PASSED **");
      end else begin
         $display("** local_history_xor_branch_predictor_core: FAILED **");
      end
      $finish;
   end

endmodule

[local_history_xor_branch_predictor_core.f]
rtl/lhx_pkg.sv
rtl/lhx_ram.sv
rtl/lhx_front.sv
rtl/lhx_queue.sv
rtl/lhx_back.sv
rtl/local_history_xor_branch_predictor_core.sv
tb/sv/lhx_pred_checker.sv
tb/sv/local_history_xor_branch_predictor_core_tb.sv
